// ===== hdl/stk_pkg.sv =====
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants of the sorted top-k norm keeper
// Holds the word formats of both channels, the cell control group and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package stk_pkg;

    // Sizes of the kept list and of one batch.
    localparam int KEEP_DEPTH    = 16;
    localparam int BATCH_DEPTH   = 1024;
    localparam int KEEP_CNT_BITS = $clog2(KEEP_DEPTH + 1);

    // Field widths.
    localparam int NORM_BITS  = 48;
    localparam int TAG_BITS   = 10;
    localparam int CNT_BITS   = 11;
    localparam int LIMIT_BITS = 5;
    localparam int RANK_BITS  = 4;

    // Configuration port.
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 64;
    localparam logic REG_GOAL  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

    // One input word.
    typedef struct packed {
        logic [NORM_BITS-1:0] norm_sq;
        logic [TAG_BITS-1:0]  vector_tag;
        logic                 batch_end;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [NORM_BITS-1:0] entry_norm;
        logic [TAG_BITS-1:0]  entry_tag;
        logic                 entry_valid;
        logic                 final_entry;
        logic [CNT_BITS-1:0]  valid_count;
        logic [NORM_BITS-1:0] min_norm;
        logic [TAG_BITS-1:0]  min_tag;
        logic [CNT_BITS-1:0]  last_valid_position;
    } out_word_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } stk_ctl_t;

endpackage

// ===== hdl/stk_cell.sv =====
// ----------------------------------------------------------------------------
// stk_cell: one slot of the sorted list
// Holds one norm and tag. On an insert it keeps its entry, takes the new
// candidate, or takes its left neighbor's entry; on a drain it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
module stk_cell (
    input  logic                          aclk,
    input  stk_pkg::stk_ctl_t             ctl,
    input  logic                          occupied,
    input  logic                          in_limit,
    input  logic                          left_lt,
    input  logic [stk_pkg::NORM_BITS-1:0] left_norm,
    input  logic [stk_pkg::TAG_BITS-1:0]  left_tag,
    input  logic [stk_pkg::NORM_BITS-1:0] right_norm,
    input  logic [stk_pkg::TAG_BITS-1:0]  right_tag,
    input  logic [stk_pkg::NORM_BITS-1:0] cand_norm,
    input  logic [stk_pkg::TAG_BITS-1:0]  cand_tag,
    output logic                          lt,
    output logic                          hit,
    output logic [stk_pkg::NORM_BITS-1:0] norm,
    output logic [stk_pkg::TAG_BITS-1:0]  tag
);

    logic [stk_pkg::NORM_BITS-1:0] norm_reg, norm_next;
    logic [stk_pkg::TAG_BITS-1:0]  tag_reg, tag_next;

    // The candidate goes behind every held entry that is strictly smaller.
    assign lt  = occupied && (norm_reg < cand_norm);
    assign hit = in_limit && left_lt && !lt;

    // Pick the next content of the slot.
    always_comb begin
        norm_next = norm_reg;
        tag_next  = tag_reg;
        if (ctl.drain) begin
            norm_next = right_norm;
            tag_next  = right_tag;
        end else if (ctl.insert) begin
            if (hit) begin
                norm_next = cand_norm;
                tag_next  = cand_tag;
            end else if (in_limit && !left_lt) begin
                norm_next = left_norm;
                tag_next  = left_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        norm_reg <= norm_next;
        tag_reg  <= tag_next;
    end

    assign norm = norm_reg;
    assign tag  = tag_reg;

endmodule

// ===== hdl/stk_chain.sv =====
// ----------------------------------------------------------------------------
// stk_chain: row of list cells
// Links the cells to their neighbors, tells each one whether it is occupied
// and within the limit, and shows the head of the list.
// ----------------------------------------------------------------------------
module stk_chain (
    input  logic                              aclk,
    input  stk_pkg::stk_ctl_t                 ctl,
    input  logic [stk_pkg::KEEP_CNT_BITS-1:0] cnt,
    input  logic [stk_pkg::KEEP_CNT_BITS-1:0] lim,
    input  logic [stk_pkg::NORM_BITS-1:0]     cand_norm,
    input  logic [stk_pkg::TAG_BITS-1:0]      cand_tag,
    output logic                              inserted,
    output logic [stk_pkg::NORM_BITS-1:0]     head_norm,
    output logic [stk_pkg::TAG_BITS-1:0]      head_tag
);

    logic [stk_pkg::KEEP_DEPTH-1:0] lt_w;
    logic [stk_pkg::KEEP_DEPTH-1:0] hit_w;
    logic [stk_pkg::KEEP_DEPTH-1:0] left_lt_w;
    logic [stk_pkg::NORM_BITS-1:0]  norm_w       [stk_pkg::KEEP_DEPTH];
    logic [stk_pkg::TAG_BITS-1:0]   tag_w        [stk_pkg::KEEP_DEPTH];
    logic [stk_pkg::NORM_BITS-1:0]  left_norm_w  [stk_pkg::KEEP_DEPTH];
    logic [stk_pkg::TAG_BITS-1:0]   left_tag_w   [stk_pkg::KEEP_DEPTH];
    logic [stk_pkg::NORM_BITS-1:0]  right_norm_w [stk_pkg::KEEP_DEPTH];
    logic [stk_pkg::TAG_BITS-1:0]   right_tag_w  [stk_pkg::KEEP_DEPTH];

    for (genvar i = 0; i < stk_pkg::KEEP_DEPTH; i++) begin : g_cell
        // Neighbor links; the ends of the row see the candidate.
        if (i == 0) begin : g_first
            assign left_lt_w[i]   = 1'b1;
            assign left_norm_w[i] = cand_norm;
            assign left_tag_w[i]  = cand_tag;
        end else begin : g_inner
            assign left_lt_w[i]   = lt_w[i-1];
            assign left_norm_w[i] = norm_w[i-1];
            assign left_tag_w[i]  = tag_w[i-1];
        end
        if (i == stk_pkg::KEEP_DEPTH - 1) begin : g_last
            assign right_norm_w[i] = cand_norm;
            assign right_tag_w[i]  = cand_tag;
        end else begin : g_body
            assign right_norm_w[i] = norm_w[i+1];
            assign right_tag_w[i]  = tag_w[i+1];
        end

        stk_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .occupied   (stk_pkg::KEEP_CNT_BITS'(i) < cnt),
            .in_limit   (stk_pkg::KEEP_CNT_BITS'(i) < lim),
            .left_lt    (left_lt_w[i]),
            .left_norm  (left_norm_w[i]),
            .left_tag   (left_tag_w[i]),
            .right_norm (right_norm_w[i]),
            .right_tag  (right_tag_w[i]),
            .cand_norm  (cand_norm),
            .cand_tag   (cand_tag),
            .lt         (lt_w[i]),
            .hit        (hit_w[i]),
            .norm       (norm_w[i]),
            .tag        (tag_w[i])
        );
    end

    // Exactly one cell takes the candidate when its place is within the limit.
    assign inserted  = |hit_w;
    assign head_norm = norm_w[0];
    assign head_tag  = tag_w[0];

endmodule

// ===== hdl/sorted_top_k_norm_keeper.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_norm_keeper: keeps the smallest candidates of a batch, sorted
// Input words (s_word) carry a squared norm, a tag and a batch end flag; a
// norm of zero is no candidate. Each accepted word is placed into a row of
// compare-and-shift cells in the cycle it is accepted, so input words are
// taken one per cycle for the whole batch.
// On the word that ends a batch, the input side closes and the list is
// drained through the output register, one result word per cycle while
// m_ready is high: one word per kept entry, or one empty word when nothing
// was kept. The first result is loaded from the drain state that the batch
// end word enters. The input reopens as soon as the last result is loaded,
// so the next batch may start while that word still waits. A stall on
// m_ready holds the drain and the result in place.
// Writes go to goal_norm_sq at 0x0 and keep_limit at 0x8 on the APB port;
// configure only between words.
// Reset empties the list, clears the batch statistics and the output valid
// flag, and sets goal_norm_sq to 0 and keep_limit to 16.
// ----------------------------------------------------------------------------
module sorted_top_k_norm_keeper (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  stk_pkg::in_word_t             s_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output stk_pkg::out_word_t            m_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stk_pkg::ADDR_BITS-1:0] paddr,
    input  logic [stk_pkg::DATA_BITS-1:0] pwdata,
    output logic [stk_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_DRAIN   = 1'b1;

    localparam logic [stk_pkg::CNT_BITS-1:0] BATCH_MAX =
        stk_pkg::CNT_BITS'(stk_pkg::BATCH_DEPTH);
    localparam logic [stk_pkg::KEEP_CNT_BITS-1:0] DEPTH_CNT =
        stk_pkg::KEEP_CNT_BITS'(stk_pkg::KEEP_DEPTH);

    logic                                state_reg, state_next;
    logic [stk_pkg::NORM_BITS-1:0]       goal_reg, goal_next;
    logic [stk_pkg::LIMIT_BITS-1:0]      limit_reg, limit_next;
    logic [stk_pkg::KEEP_CNT_BITS-1:0]   kept_reg, kept_next;
    logic [stk_pkg::NORM_BITS-1:0]       small_norm_reg, small_norm_next;
    logic [stk_pkg::TAG_BITS-1:0]        small_tag_reg, small_tag_next;
    logic [stk_pkg::CNT_BITS-1:0]        proc_cnt_reg, proc_cnt_next;
    logic [stk_pkg::CNT_BITS-1:0]        batch_pos_reg, batch_pos_next;
    logic [stk_pkg::CNT_BITS-1:0]        last_pos_reg, last_pos_next;
    logic                                empty_reg, empty_next;
    logic [stk_pkg::RANK_BITS-1:0]       rank_reg, rank_next;
    logic                                m_valid_reg, m_valid_next;
    stk_pkg::out_word_t                  m_word_reg, m_word_next;

    logic                                wr_en;
    logic                                take;
    logic                                process;
    logic                                load;
    logic                                last_word;
    logic                                inserted;
    logic [stk_pkg::KEEP_CNT_BITS-1:0]   lim;
    logic [stk_pkg::KEEP_CNT_BITS-1:0]   cnt;
    logic [stk_pkg::KEEP_CNT_BITS-1:0]   cnt_after;
    logic [stk_pkg::CNT_BITS-1:0]        pos_plus;
    logic [stk_pkg::NORM_BITS-1:0]       head_norm;
    logic [stk_pkg::TAG_BITS-1:0]        head_tag;
    stk_pkg::stk_ctl_t                   ctl;

    // Configuration port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        goal_next  = goal_reg;
        limit_next = limit_reg;
        prdata     = '0;
        unique case (paddr[3])
            stk_pkg::REG_GOAL: begin
                prdata = stk_pkg::DATA_BITS'(goal_reg);
                if (wr_en) begin
                    goal_next = pwdata[stk_pkg::NORM_BITS-1:0];
                end
            end
            stk_pkg::REG_LIMIT: begin
                prdata = stk_pkg::DATA_BITS'(limit_reg);
                if (wr_en) begin
                    limit_next = pwdata[stk_pkg::LIMIT_BITS-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Effective limit and the part of the list that is still live.
    always_comb begin
        if (limit_reg == '0) begin
            lim = stk_pkg::KEEP_CNT_BITS'(1);
        end else if (stk_pkg::KEEP_CNT_BITS'(limit_reg) > DEPTH_CNT) begin
            lim = DEPTH_CNT;
        end else begin
            lim = stk_pkg::KEEP_CNT_BITS'(limit_reg);
        end
        cnt = (kept_reg < lim) ? kept_reg : lim;
    end

    // Handshake and cell commands.
    assign s_ready   = (state_reg == ST_COLLECT);
    assign take      = s_valid && s_ready;
    assign process   = take && (goal_reg < small_norm_reg) && (s_word.norm_sq != '0);
    assign load      = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);
    assign last_word = empty_reg || (kept_reg == stk_pkg::KEEP_CNT_BITS'(1));
    assign ctl.insert = process;
    assign ctl.drain  = load;

    stk_chain u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .cnt       (cnt),
        .lim       (lim),
        .cand_norm (s_word.norm_sq),
        .cand_tag  (s_word.vector_tag),
        .inserted  (inserted),
        .head_norm (head_norm),
        .head_tag  (head_tag)
    );

    // List length after the current word.
    always_comb begin
        cnt_after = kept_reg;
        if (process) begin
            cnt_after = (inserted && (cnt < lim)) ? cnt + 1'b1 : cnt;
        end
    end

    // Batch statistics, list length and drain control.
    always_comb begin
        state_next      = state_reg;
        kept_next       = kept_reg;
        small_norm_next = small_norm_reg;
        small_tag_next  = small_tag_reg;
        proc_cnt_next   = proc_cnt_reg;
        batch_pos_next  = batch_pos_reg;
        last_pos_next   = last_pos_reg;
        empty_next      = empty_reg;
        rank_next       = rank_reg;
        pos_plus        = batch_pos_reg + 1'b1;

        if (take) begin
            if (batch_pos_reg < BATCH_MAX) begin
                batch_pos_next = pos_plus;
            end
            kept_next = cnt_after;
            if (process) begin
                last_pos_next = (pos_plus > BATCH_MAX) ? BATCH_MAX : pos_plus;
                if (s_word.norm_sq < small_norm_reg) begin
                    small_norm_next = s_word.norm_sq;
                    small_tag_next  = s_word.vector_tag;
                end
                if (proc_cnt_reg < BATCH_MAX) begin
                    proc_cnt_next = proc_cnt_reg + 1'b1;
                end
            end
            if (s_word.batch_end) begin
                // Trim to the limit and start the drain.
                kept_next  = (cnt_after < lim) ? cnt_after : lim;
                empty_next = (cnt_after == '0);
                rank_next  = '0;
                state_next = ST_DRAIN;
            end
        end

        if (load) begin
            rank_next = rank_reg + 1'b1;
            kept_next = kept_reg - 1'b1;
            if (last_word) begin
                // Last result loaded: clear the batch and reopen the input.
                state_next      = ST_COLLECT;
                kept_next       = '0;
                small_norm_next = '1;
                small_tag_next  = '0;
                proc_cnt_next   = '0;
                batch_pos_next  = '0;
                last_pos_next   = '0;
                rank_next       = '0;
            end
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (load) begin
            m_valid_next                    = 1'b1;
            m_word_next.rank                = rank_reg;
            m_word_next.entry_norm          = empty_reg ? '0 : head_norm;
            m_word_next.entry_tag           = empty_reg ? '0 : head_tag;
            m_word_next.entry_valid         = !empty_reg;
            m_word_next.final_entry         = last_word;
            m_word_next.valid_count         = proc_cnt_reg;
            m_word_next.min_norm            = small_norm_reg;
            m_word_next.min_tag             = small_tag_reg;
            m_word_next.last_valid_position = last_pos_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_COLLECT;
            goal_reg       <= '0;
            limit_reg      <= stk_pkg::LIMIT_RESET;
            kept_reg       <= '0;
            small_norm_reg <= '1;
            small_tag_reg  <= '0;
            proc_cnt_reg   <= '0;
            batch_pos_reg  <= '0;
            last_pos_reg   <= '0;
            empty_reg      <= 1'b0;
            rank_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            goal_reg       <= goal_next;
            limit_reg      <= limit_next;
            kept_reg       <= kept_next;
            small_norm_reg <= small_norm_next;
            small_tag_reg  <= small_tag_next;
            proc_cnt_reg   <= proc_cnt_next;
            batch_pos_reg  <= batch_pos_next;
            last_pos_reg   <= last_pos_next;
            empty_reg      <= empty_next;
            rank_reg       <= rank_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== hdl/stk_checker.sv =====
// ----------------------------------------------------------------------------
// stk_checker: port-level checks of the sorted top-k norm keeper
// Watches the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module stk_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input stk_pkg::out_word_t m_word
);

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // The input stays closed until the last word of a batch is loaded.
    a_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.final_entry |-> !s_ready)
        else $error("input open during the drain");

    // Results of a batch follow back to back with rising rank.
    a_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_word.final_entry |=>
            m_valid && (m_word.rank == stk_pkg::RANK_BITS'($past(m_word.rank) + 1'b1)))
        else $error("rank did not advance by one");

    // An empty list gives a single word.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.entry_valid |-> m_word.final_entry && (m_word.rank == '0))
        else $error("empty result is not a lone word");

    // The count of candidates never passes the last candidate position.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.valid_count <= m_word.last_valid_position)
        else $error("candidate count exceeds last position");

endmodule

bind sorted_top_k_norm_keeper stk_checker u_stk_checker (.*);

// ===== verif/sorted_top_k_norm_keeper_test.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_norm_keeper_test: self-checking bench of the top-k norm keeper
// Drives batches of candidate words into the block and writes both registers
// over the APB port. A behavioral model of the sorted list predicts every
// result word, and a scoreboard compares each one field by field. Directed
// tests cover empty batches, norm extremes, ties, the goal cutoff, limits
// out of range and a limit lowered mid-batch. Random batches then run under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_top_k_norm_keeper_test;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    stk_pkg::in_word_t                    s_word;
    logic                                 m_valid;
    logic                                 m_ready;
    stk_pkg::out_word_t                   m_word;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [stk_pkg::ADDR_BITS-1:0]        paddr;
    logic [stk_pkg::DATA_BITS-1:0]        pwdata;
    logic [stk_pkg::DATA_BITS-1:0]        prdata;
    logic                                 pready;

    localparam logic [stk_pkg::NORM_BITS-1:0] NORM_ALL_ONES = '1;

    sorted_top_k_norm_keeper u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model of the sorted list and the batch statistics.
    logic [stk_pkg::NORM_BITS-1:0]  kept_norm [stk_pkg::KEEP_DEPTH];
    logic [stk_pkg::TAG_BITS-1:0]   kept_tag  [stk_pkg::KEEP_DEPTH];
    int unsigned                    kept_n;
    logic [stk_pkg::NORM_BITS-1:0]  best_norm;
    logic [stk_pkg::TAG_BITS-1:0]   best_tag;
    int unsigned                    cand_count;
    int unsigned                    batch_pos;
    int unsigned                    last_pos;
    logic [stk_pkg::NORM_BITS-1:0]  cfg_goal;
    logic [stk_pkg::LIMIT_BITS-1:0] cfg_limit;

    // Result words still owed by the block, oldest first.
    stk_pkg::out_word_t pending_entries[$];
    stk_pkg::out_word_t want;

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned words_sent;
    int unsigned batches_sent;
    int unsigned entries_checked;

    // Clock.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned active_limit();
        int unsigned lim;
        lim = cfg_limit;
        if (lim == 0) lim = 1;
        if (lim > stk_pkg::KEEP_DEPTH) lim = stk_pkg::KEEP_DEPTH;
        return lim;
    endfunction

    function automatic void clear_batch();
        kept_n     = 0;
        best_norm  = NORM_ALL_ONES;
        best_tag   = '0;
        cand_count = 0;
        batch_pos  = 0;
        last_pos   = 0;
    endfunction

    // Insert after every kept entry that is strictly smaller; a full list
    // drops its largest entry.
    function automatic void insert_candidate(logic [stk_pkg::NORM_BITS-1:0] norm,
                                             logic [stk_pkg::TAG_BITS-1:0] tag);
        int unsigned lim;
        int unsigned cnt;
        int unsigned pos;
        int unsigned tail;
        lim = active_limit();
        cnt = (kept_n < lim) ? kept_n : lim;
        pos = 0;
        while (pos < cnt && kept_norm[pos] < norm) pos++;
        kept_n = cnt;
        if (pos >= lim) return;
        tail = (cnt < lim) ? cnt : lim - 1;
        for (int j = tail; j > pos; j--) begin
            kept_norm[j] = kept_norm[j-1];
            kept_tag[j]  = kept_tag[j-1];
        end
        kept_norm[pos] = norm;
        kept_tag[pos]  = tag;
        if (cnt < lim) kept_n = cnt + 1;
    endfunction

    // Update the model with one accepted word and queue its result words.
    function automatic void track_word(stk_pkg::in_word_t w);
        int unsigned        pos_now;
        int unsigned        cnt;
        int unsigned        n;
        stk_pkg::out_word_t r;
        pos_now = batch_pos;
        if (batch_pos < stk_pkg::BATCH_DEPTH) batch_pos++;
        if (cfg_goal < best_norm && w.norm_sq != '0) begin
            last_pos = (pos_now + 1 > stk_pkg::BATCH_DEPTH) ? stk_pkg::BATCH_DEPTH
                                                             : pos_now + 1;
            insert_candidate(w.norm_sq, w.vector_tag);
            if (w.norm_sq < best_norm) begin
                best_norm = w.norm_sq;
                best_tag  = w.vector_tag;
            end
            if (cand_count < stk_pkg::BATCH_DEPTH) cand_count++;
        end
        if (!w.batch_end) return;
        cnt = (kept_n < active_limit()) ? kept_n : active_limit();
        n   = (cnt == 0) ? 1 : cnt;
        for (int k = 0; k < n; k++) begin
            r.rank                = stk_pkg::RANK_BITS'(k);
            r.entry_norm          = (cnt != 0) ? kept_norm[k] : '0;
            r.entry_tag           = (cnt != 0) ? kept_tag[k] : '0;
            r.entry_valid         = (cnt != 0);
            r.final_entry         = (k + 1 == n);
            r.valid_count         = stk_pkg::CNT_BITS'(cand_count);
            r.min_norm            = best_norm;
            r.min_tag             = best_tag;
            r.last_valid_position = stk_pkg::CNT_BITS'(last_pos);
            pending_entries = {pending_entries, r};
        end
        clear_batch();
    endfunction

    function automatic void check_field(string name, logic [63:0] expected,
                                        logic [63:0] actual);
        if (expected !== actual) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatch_count++;
        end
    endfunction

    // Receiver: random stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Scoreboard: every accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            entries_checked++;
            if (pending_entries.size() == 0) begin
                $error("result word with none expected: rank %0d norm 0x%0h",
                       m_word.rank, m_word.entry_norm);
                mismatch_count++;
            end else begin
                want = pending_entries.pop_front();
                check_field("rank", 64'(want.rank), 64'(m_word.rank));
                check_field("entry_norm", 64'(want.entry_norm), 64'(m_word.entry_norm));
                check_field("entry_tag", 64'(want.entry_tag), 64'(m_word.entry_tag));
                check_field("entry_valid", 64'(want.entry_valid),
                            64'(m_word.entry_valid));
                check_field("final_entry", 64'(want.final_entry),
                            64'(m_word.final_entry));
                check_field("valid_count", 64'(want.valid_count),
                            64'(m_word.valid_count));
                check_field("min_norm", 64'(want.min_norm), 64'(m_word.min_norm));
                check_field("min_tag", 64'(want.min_tag), 64'(m_word.min_tag));
                check_field("last_valid_position", 64'(want.last_valid_position),
                            64'(m_word.last_valid_position));
            end
        end
    end

    // Send one word, with random gaps before it; valid stays high after
    // acceptance so that back-to-back words need no second assignment.
    task automatic send_word(input logic [stk_pkg::NORM_BITS-1:0] norm,
                             input logic [stk_pkg::TAG_BITS-1:0] tag, input logic last);
        stk_pkg::in_word_t w;
        w.norm_sq    = norm;
        w.vector_tag = tag;
        w.batch_end  = last;
        if ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_gap_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        track_word(w);
        words_sent++;
        if (last) batches_sent++;
    endtask

    // Stop sending, let every owed result arrive, then let the block settle
    // before anything is reconfigured.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_index,
                             input logic [stk_pkg::DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == stk_pkg::REG_GOAL) cfg_goal = value[stk_pkg::NORM_BITS-1:0];
        else cfg_limit = value[stk_pkg::LIMIT_BITS-1:0];
        @(posedge aclk);
    endtask

    task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Norms with a bias toward ties, zeros and the extremes.
    function automatic logic [stk_pkg::NORM_BITS-1:0] pick_norm();
        case ($urandom_range(9)) inside
            0:       return '0;
            1:       return NORM_ALL_ONES;
            2:       return stk_pkg::NORM_BITS'($urandom_range(1, 8));
            [3:5]:   return stk_pkg::NORM_BITS'($urandom_range(1, 1000));
            default: return stk_pkg::NORM_BITS'({$urandom, $urandom});
        endcase
    endfunction

    // An empty batch, then a batch of one candidate.
    task automatic test_empty_and_single();
        send_word('0, 10'd1023, 1'b1);
        send_word(48'd42, 10'd7, 1'b1);
        wait_drained();
    endtask

    // Smallest and largest norms and tags; a norm of all ones never lowers
    // the minimum.
    task automatic test_norm_extremes();
        send_word(NORM_ALL_ONES, 10'd0, 1'b0);
        send_word(48'd1, 10'd1023, 1'b0);
        send_word(48'h8000_0000_0000, 10'd512, 1'b0);
        send_word(48'h7FFF_FFFF_FFFF, 10'd341, 1'b1);
        send_word(NORM_ALL_ONES, 10'd682, 1'b1);
        wait_drained();
    endtask

    // Ties go ahead of kept entries of equal norm; on a full list a new tie
    // still enters and the last kept entry drops out.
    task automatic test_equal_norms();
        apb_write(stk_pkg::REG_LIMIT, 64'd3);
        send_word(48'd5, 10'd1, 1'b0);
        send_word(48'd5, 10'd2, 1'b0);
        send_word(48'd5, 10'd3, 1'b0);
        send_word(48'd5, 10'd4, 1'b0);
        send_word(48'd3, 10'd5, 1'b1);
        wait_drained();
    endtask

    // Once the minimum reaches the goal, the rest of the batch is ignored;
    // a goal of all ones ignores everything.
    task automatic test_goal_cutoff();
        apb_write(stk_pkg::REG_LIMIT, 64'd16);
        apb_write(stk_pkg::REG_GOAL, 64'd100);
        send_word(48'd500, 10'd1, 1'b0);
        send_word(48'd90, 10'd2, 1'b0);
        send_word(48'd50, 10'd3, 1'b0);
        send_word('0, 10'd4, 1'b1);
        wait_drained();
        apb_write(stk_pkg::REG_GOAL, 64'(NORM_ALL_ONES));
        send_word(48'd7, 10'd5, 1'b0);
        send_word(48'd8, 10'd6, 1'b1);
        wait_drained();
        apb_write(stk_pkg::REG_GOAL, 64'd0);
    endtask

    // A limit of zero acts as one, and one above the depth as the depth.
    task automatic test_limit_range();
        apb_write(stk_pkg::REG_LIMIT, 64'd0);
        send_word(48'd30, 10'd1, 1'b0);
        send_word(48'd10, 10'd2, 1'b0);
        send_word(48'd20, 10'd3, 1'b1);
        wait_drained();
        apb_write(stk_pkg::REG_LIMIT, 64'd31);
        send_word(48'd9, 10'd4, 1'b0);
        send_word(48'd3, 10'd5, 1'b1);
        wait_drained();
    endtask

    // Lowering the limit inside a batch trims the list at the next insertion
    // or at the emission.
    task automatic test_limit_lowered();
        apb_write(stk_pkg::REG_LIMIT, 64'd8);
        send_word(48'd40, 10'd1, 1'b0);
        send_word(48'd10, 10'd2, 1'b0);
        send_word(48'd30, 10'd3, 1'b0);
        send_word(48'd20, 10'd4, 1'b0);
        wait_drained();
        apb_write(stk_pkg::REG_LIMIT, 64'd2);
        send_word(48'd25, 10'd5, 1'b1);
        wait_drained();
        apb_write(stk_pkg::REG_LIMIT, 64'd8);
        send_word(48'd60, 10'd6, 1'b0);
        send_word(48'd15, 10'd7, 1'b0);
        wait_drained();
        apb_write(stk_pkg::REG_LIMIT, 64'd1);
        send_word('0, 10'd8, 1'b1);
        wait_drained();
    endtask

    // Random batches of random length under one idling pattern.
    task automatic test_random_batches(input int unsigned gap_pct,
                                       input int unsigned stall_pct);
        int unsigned                   counted;
        int unsigned                   len;
        logic [stk_pkg::NORM_BITS-1:0] norm;
        counted = 0;
        set_idling(gap_pct, stall_pct);
        case ($urandom_range(3)) inside
            [0:1]:   apb_write(stk_pkg::REG_GOAL, 64'd0);
            2:       apb_write(stk_pkg::REG_GOAL, 64'($urandom_range(1, 50)));
            default: apb_write(stk_pkg::REG_GOAL,
                               64'({$urandom, $urandom} & 48'hFF_FFFF_FFFF));
        endcase
        case ($urandom_range(5))
            0:       apb_write(stk_pkg::REG_LIMIT, 64'd1);
            1:       apb_write(stk_pkg::REG_LIMIT, 64'd16);
            2:       apb_write(stk_pkg::REG_LIMIT, 64'($urandom_range(0, 31)));
            default: apb_write(stk_pkg::REG_LIMIT, 64'($urandom_range(1, 16)));
        endcase
        while (counted < 30) begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
                norm = pick_norm();
                if (norm != '0) counted++;
                send_word(norm, stk_pkg::TAG_BITS'($urandom), i == len - 1);
            end
        end
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_word         = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        words_sent     = 0;
        batches_sent   = 0;
        entries_checked = 0;
        cfg_goal       = '0;
        cfg_limit      = stk_pkg::LIMIT_RESET;
        for (int i = 0; i < stk_pkg::KEEP_DEPTH; i++) begin
            kept_norm[i] = '0;
            kept_tag[i]  = '0;
        end
        clear_batch();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_empty_and_single();
        test_norm_extremes();
        test_equal_norms();
        test_goal_cutoff();
        test_limit_range();
        test_limit_lowered();
        test_random_batches(0, 0);
        test_random_batches(68, 0);
        test_random_batches(0, 68);
        test_random_batches(14, 14);
        set_idling(0, 0);
        wait_drained();

        $display("Sent %0d words in %0d batches and checked %0d result words.",
                 words_sent, batches_sent, entries_checked);
        $display("Covered ties, goal cutoff, limits 0 to 31, mid-batch limit change");
        $display("and random batches with gaps and stalls on both channels.");
        if (mismatch_count == 0 && pending_entries.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/stk_pkg.sv
hdl/stk_cell.sv
hdl/stk_chain.sv
hdl/sorted_top_k_norm_keeper.sv
hdl/stk_checker.sv
verif/sorted_top_k_norm_keeper_test.sv
